FILE: hw/rtl/mwus_pkg.sv
// shared types and constants of the max weight unit scheduler
`timescale 1ns / 1ps

package mwus_pkg;

   localparam int OPCODE_W = 2;
   localparam int WEIGHT_W = 16;
   localparam int UNITS_W  = 16;
   localparam int PROD_W   = WEIGHT_W + UNITS_W;
   localparam int PEN_W    = 48;

   localparam logic [PEN_W-1:0] PEN_MAX = {PEN_W{1'b1}};

   // transaction opcodes, code 3 is a no-op
   typedef enum logic [OPCODE_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   // one slot of the job table
   typedef struct packed {
      logic                vld;
      logic [WEIGHT_W-1:0] weight;
      logic [UNITS_W-1:0]  units;
   } entry_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } ctrl_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic latch;
      logic cnt_clr;
      logic cnt_inc;
      logic mem_clr;
      logic rd_en;
      logic commit;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic addr_last;
      logic out_free;
   } dp_stat_type;

endpackage

FILE: hw/rtl/mwus_req_if.sv
// request channel interface of the scheduler
`timescale 1ns / 1ps

interface mwus_req_if import mwus_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [WEIGHT_W-1:0] job_weight;
   logic [UNITS_W-1:0]  job_units;

   modport source (output valid, opcode, job_weight, job_units, input ready);
   modport sink   (input valid, opcode, job_weight, job_units, output ready);
endinterface

FILE: hw/rtl/mwus_rsp_if.sv
// response channel interface of the scheduler
`timescale 1ns / 1ps

interface mwus_rsp_if import mwus_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [WEIGHT_W-1:0] served_weight;
   logic                served_valid;
   logic                table_full;
   logic [PEN_W-1:0]    total_penalty;

   modport source (output valid, served_weight, served_valid, table_full, total_penalty,
                   input ready);
   modport sink   (input valid, served_weight, served_valid, table_full, total_penalty,
                   output ready);
endinterface

FILE: hw/rtl/mwus_ctrl.sv
// sequencing state machine of the scheduler
`timescale 1ns / 1ps

module mwus_ctrl import mwus_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic                req_units_zero,
   output logic                req_ready,
   input  dp_stat_type         stat,
   output dp_cmd_type          cmd
);

   ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.mem_clr = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (stat.addr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch   = 1'b1;
               cmd.cnt_clr = 1'b1;
               case (op_type'(req_opcode))
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_ADD:   state_in = req_units_zero ? ST_COMMIT : ST_SCAN;
                  OP_TICK:  state_in = ST_SCAN;
                  default:  state_in = ST_COMMIT;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.mem_clr = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (stat.addr_last) state_in = ST_COMMIT;
         end
         ST_SCAN: begin
            cmd.rd_en   = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (stat.addr_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

FILE: hw/rtl/mwus_datapath.sv
// job table, scan trackers, penalty and response register of the scheduler
`timescale 1ns / 1ps

module mwus_datapath import mwus_pkg::*; #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [WEIGHT_W-1:0] req_job_weight,
   input  logic [UNITS_W-1:0]  req_job_units,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [WEIGHT_W-1:0] rsp_served_weight,
   output logic                rsp_served_valid,
   output logic                rsp_table_full,
   output logic [PEN_W-1:0]    rsp_total_penalty
);

   localparam int AW = $clog2(TABLE_ENTRIES);

   entry_type           entry_mem [TABLE_ENTRIES];

   logic [AW-1:0]       addr_ff;
   logic                rd_vld_ff;
   logic [AW-1:0]       rd_idx_ff;
   entry_type           rd_data_ff;

   logic                free_found_ff;
   logic [AW-1:0]       free_idx_ff;
   logic                best_found_ff;
   logic [AW-1:0]       best_idx_ff;
   entry_type           best_ff;

   op_type              op_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [UNITS_W-1:0]  units_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [PEN_W-1:0]    penalty_ff, penalty_in;

   logic                rsp_valid_ff;
   logic [WEIGHT_W-1:0] sw_ff, sw_in;
   logic                sv_ff, sv_in;
   logic                full_ff, full_in;
   logic [PEN_W-1:0]    rsp_pen_ff;

   logic                upd_we;
   logic [AW-1:0]       upd_addr;
   entry_type           upd_data;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   entry_type           mem_wdata;

   logic [PEN_W:0]      pen_sum;
   logic [UNITS_W-1:0]  units_dec;
   logic                out_free;

   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign stat.out_free  = out_free;
   assign stat.addr_last = (addr_ff == AW'(TABLE_ENTRIES - 1));

   // table address counter
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else if (cmd.cnt_clr) begin
         addr_ff <= '0;
      end else if (cmd.cnt_inc) begin
         addr_ff <= addr_ff + AW'(1);
      end
   end

   // table write port: clearing sweep or commit update
   always_comb begin
      mem_we    = cmd.mem_clr || (cmd.commit && upd_we);
      mem_waddr = cmd.mem_clr ? addr_ff : upd_addr;
      mem_wdata = cmd.mem_clr ? entry_type'('0) : upd_data;
   end

   // job table memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) entry_mem[mem_waddr] <= mem_wdata;
      if (cmd.rd_en) begin
         rd_data_ff <= entry_mem[addr_ff];
         rd_idx_ff  <= addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
      end
   end

   // scan trackers: lowest free slot and best waiting job
   always_ff @(posedge clock) begin
      if (reset || cmd.latch) begin
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
      end else if (rd_vld_ff) begin
         if (!rd_data_ff.vld && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
         if (rd_data_ff.vld && (!best_found_ff ||
             rd_data_ff.weight > best_ff.weight ||
             (rd_data_ff.weight == best_ff.weight &&
              rd_data_ff.units > best_ff.units))) begin
            best_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         if (!rd_data_ff.vld && !free_found_ff) begin
            free_idx_ff <= rd_idx_ff;
         end
         if (rd_data_ff.vld && (!best_found_ff ||
             rd_data_ff.weight > best_ff.weight ||
             (rd_data_ff.weight == best_ff.weight &&
              rd_data_ff.units > best_ff.units))) begin
            best_ff     <= rd_data_ff;
            best_idx_ff <= rd_idx_ff;
         end
      end
   end

   // capture the accepted transaction and its penalty product
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff     <= op_type'(req_opcode);
         weight_ff <= req_job_weight;
         units_ff  <= req_job_units;
         prod_ff   <= PROD_W'(req_job_weight) * PROD_W'(req_job_units);
      end
   end

   // commit: table update, penalty and result fields
   always_comb begin
      pen_sum    = {1'b0, penalty_ff} + (PEN_W + 1)'(prod_ff);
      units_dec  = best_ff.units - UNITS_W'(1);
      penalty_in = penalty_ff;
      upd_we     = 1'b0;
      upd_addr   = best_idx_ff;
      upd_data   = '0;
      sw_in      = '0;
      sv_in      = 1'b0;
      full_in    = 1'b0;
      case (op_ff)
         OP_CLEAR: begin
            penalty_in = '0;
         end
         OP_ADD: begin
            if (units_ff != '0) begin
               if (free_found_ff) begin
                  upd_we          = 1'b1;
                  upd_addr        = free_idx_ff;
                  upd_data.vld    = 1'b1;
                  upd_data.weight = weight_ff;
                  upd_data.units  = units_ff;
                  penalty_in      = pen_sum[PEN_W] ? PEN_MAX : pen_sum[PEN_W-1:0];
               end else begin
                  full_in = 1'b1;
               end
            end
         end
         OP_TICK: begin
            if (best_found_ff) begin
               upd_we          = 1'b1;
               upd_data.vld    = (units_dec != '0);
               upd_data.weight = best_ff.weight;
               upd_data.units  = units_dec;
               sw_in           = best_ff.weight;
               sv_in           = 1'b1;
               if (penalty_ff >= PEN_W'(best_ff.weight)) begin
                  penalty_in = penalty_ff - PEN_W'(best_ff.weight);
               end else begin
                  penalty_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // penalty register
   always_ff @(posedge clock) begin
      if (reset) begin
         penalty_ff <= '0;
      end else if (cmd.commit) begin
         penalty_ff <= penalty_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         sw_ff      <= sw_in;
         sv_ff      <= sv_in;
         full_ff    <= full_in;
         rsp_pen_ff <= penalty_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_served_weight = sw_ff;
   assign rsp_served_valid  = sv_ff;
   assign rsp_table_full    = full_ff;
   assign rsp_total_penalty = rsp_pen_ff;

endmodule

FILE: hw/rtl/max_weight_unit_scheduler_unit.sv
// Highest-weight-first unit job scheduler. Each request transaction (clear,
// add job, tick) yields exactly one response transaction. The job table is a
// single-port memory of TABLE_ENTRIES slots that is swept one slot per cycle.
// An add with nonzero units or a tick scans the whole table, drains the read
// and commits; a clear sweeps the table with zeros and commits; a zero-unit
// add or opcode 3 goes straight to commit. After reset the table is cleared
// by a full sweep during which no request is accepted. A waiting response
// does not stop the next request from being accepted; the block stalls only
// at commit while the previous response is still held.
`timescale 1ns / 1ps

module max_weight_unit_scheduler_unit import mwus_pkg::*; #(
   parameter int TABLE_ENTRIES = 64
) (
   input logic       clock,
   input logic       reset,
   mwus_req_if.sink   req_bus,
   mwus_rsp_if.source rsp_bus
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencing
   mwus_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_opcode     (req_bus.opcode),
      .req_units_zero (req_bus.job_units == '0),
      .req_ready      (req_bus.ready),
      .stat           (stat),
      .cmd            (cmd)
   );

   // table, search and penalty
   mwus_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_bus.opcode),
      .req_job_weight    (req_bus.job_weight),
      .req_job_units     (req_bus.job_units),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_served_weight (rsp_bus.served_weight),
      .rsp_served_valid  (rsp_bus.served_valid),
      .rsp_table_full    (rsp_bus.table_full),
      .rsp_total_penalty (rsp_bus.total_penalty)
   );

`ifndef SYNTHESIS
   // one transaction at a time: ready drops right after an acceptance
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while previous one still in progress");

   // a tick result never also reports a dropped add
   a_served_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.served_valid && rsp_bus.table_full))
      else $error("response flags both served and table full");

   // no served unit means a zero weight field
   a_weight_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.served_valid) |-> (rsp_bus.served_weight == '0))
      else $error("served weight nonzero without a served unit");
`endif

endmodule

FILE: verif/tb_top.sv
// self-checking testbench of the max weight unit scheduler
`timescale 1ns / 1ps

module tb_top;
   import mwus_pkg::*;

   localparam int          ENTRIES     = 64;
   localparam int          STALL_LIMIT = 5000;
   localparam int          MAX_PRINTS  = 50;
   // opcode 3 is unused by the block and acts as a no-op
   localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;

   // one expected response transaction
   typedef struct packed {
      logic [WEIGHT_W-1:0] served_weight;
      logic                served_valid;
      logic                table_full;
      logic [PEN_W-1:0]    total_penalty;
   } sched_result_type;

   logic clock;
   logic reset;

   mwus_req_if req_bus ();
   mwus_rsp_if rsp_bus ();

   max_weight_unit_scheduler_unit #(
      .TABLE_ENTRIES (ENTRIES)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // shadow copy of the job table and the owed penalty
   bit                  job_vld    [ENTRIES];
   logic [WEIGHT_W-1:0] job_weight [ENTRIES];
   logic [UNITS_W-1:0]  job_units  [ENTRIES];
   logic [PEN_W-1:0]    owed_penalty = '0;

   sched_result_type pending_results[$];

   int unsigned mismatch_count = 0;
   int unsigned stall_cycles = 0;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   // clock generation
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // work out the response of one request and update the shadow table
   function automatic sched_result_type schedule_request(logic [OPCODE_W-1:0] op,
                                                         logic [WEIGHT_W-1:0] w,
                                                         logic [UNITS_W-1:0]  u);
      sched_result_type res;
      logic [PEN_W:0]   sum;
      int               slot;
      int               best;
      bit               found;
      res   = '0;
      slot  = -1;
      best  = 0;
      found = 1'b0;
      case (op)
         OP_CLEAR: begin
            for (int i = 0; i < ENTRIES; i++) job_vld[i] = 1'b0;
            owed_penalty = '0;
         end
         OP_ADD: begin
            // zero units is a no-op
            if (u != '0) begin
               for (int i = ENTRIES - 1; i >= 0; i--)
                  if (!job_vld[i]) slot = i;
               if (slot < 0) begin
                  res.table_full = 1'b1;
               end else begin
                  job_vld[slot]    = 1'b1;
                  job_weight[slot] = w;
                  job_units[slot]  = u;
                  sum = {1'b0, owed_penalty} + (PEN_W + 1)'(w) * (PEN_W + 1)'(u);
                  owed_penalty = sum[PEN_W] ? PEN_MAX : sum[PEN_W-1:0];
               end
            end
         end
         OP_TICK: begin
            // largest weight, then larger count, then lower slot
            for (int i = 0; i < ENTRIES; i++) begin
               if (job_vld[i] && (!found || job_weight[i] > job_weight[best] ||
                   (job_weight[i] == job_weight[best] && job_units[i] > job_units[best]))) begin
                  best  = i;
                  found = 1'b1;
               end
            end
            if (found) begin
               res.served_valid  = 1'b1;
               res.served_weight = job_weight[best];
               owed_penalty = (owed_penalty >= PEN_W'(job_weight[best])) ?
                              owed_penalty - PEN_W'(job_weight[best]) : '0;
               job_units[best] = job_units[best] - UNITS_W'(1);
               if (job_units[best] == '0) job_vld[best] = 1'b0;
            end
         end
         default: ;
      endcase
      res.total_penalty = owed_penalty;
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] exp_val);
      if (mismatch_count < MAX_PRINTS)
         $display("mismatch %s: got %0h expected %0h at %0t", field, got, exp_val, $realtime);
      mismatch_count++;
   endtask

   // response ready with random back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // check responses, predict accepted requests, count quiet cycles
   always @(posedge clock) begin : monitor
      sched_result_type exp_res;
      bit               moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected transaction", 64'(rsp_bus.total_penalty), '0);
            end else begin
               exp_res = pending_results.pop_front();
               if (rsp_bus.served_weight !== exp_res.served_weight)
                  report_mismatch("served_weight", 64'(rsp_bus.served_weight),
                                  64'(exp_res.served_weight));
               if (rsp_bus.served_valid !== exp_res.served_valid)
                  report_mismatch("served_valid", 64'(rsp_bus.served_valid),
                                  64'(exp_res.served_valid));
               if (rsp_bus.table_full !== exp_res.table_full)
                  report_mismatch("table_full", 64'(rsp_bus.table_full),
                                  64'(exp_res.table_full));
               if (rsp_bus.total_penalty !== exp_res.total_penalty)
                  report_mismatch("total_penalty", 64'(rsp_bus.total_penalty),
                                  64'(exp_res.total_penalty));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            moved = 1'b1;
            pending_results.insert(pending_results.size(),
                                   schedule_request(req_bus.opcode, req_bus.job_weight,
                                                    req_bus.job_units));
         end
         stall_cycles <= moved ? 0 : stall_cycles + 1;
      end
   end

   // watchdog on cycles with no transaction on either channel
   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("status: fail");
      $finish;
   end

   // present one request and hold it until accepted
   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [WEIGHT_W-1:0] w,
                               input logic [UNITS_W-1:0] u);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.job_weight <= w;
      req_bus.job_units  <= u;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // stop sending until every response has come back
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 50) return WEIGHT_W'($urandom_range(7));
      if (roll < 90) return WEIGHT_W'($urandom);
      return ($urandom_range(1) != 0) ? '1 : '0;
   endfunction

   function automatic logic [UNITS_W-1:0] pick_units();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return UNITS_W'($urandom_range(4, 1));
      if (roll < 90) return UNITS_W'($urandom_range(64, 1));
      return UNITS_W'($urandom_range(65535, 1));
   endfunction

   // corner cases: empty table, extremes, zero weight, zero units, ties, unused opcode
   task automatic test_directed();
      send_request(OP_TICK, '1, '1);
      send_request(OP_ADD, '1, '1);
      send_request(OP_TICK, '0, '0);
      send_request(OP_NOP, '1, '1);
      send_request(OP_CLEAR, '1, '1);
      send_request(OP_TICK, '0, '0);
      send_request(OP_ADD, '0, 16'd1);
      send_request(OP_ADD, 16'h1234, '0);
      send_request(OP_TICK, '0, '0);
      send_request(OP_TICK, '0, '0);
      send_request(OP_ADD, 16'd100, 16'd2);
      send_request(OP_ADD, 16'd100, 16'd5);
      send_request(OP_ADD, 16'd7, 16'd1);
      send_request(OP_ADD, 16'h8000, 16'h8000);
      send_request(OP_NOP, '0, '0);
      repeat (7) send_request(OP_TICK, '0, '0);
      send_request(OP_CLEAR, '0, '0);
   endtask

   // fill every slot, then add past the end of the table
   task automatic test_table_full();
      send_request(OP_CLEAR, '0, '0);
      repeat (ENTRIES) send_request(OP_ADD, WEIGHT_W'($urandom), pick_units());
      send_request(OP_ADD, '1, '1);
      send_request(OP_ADD, 16'd5, '0);
      send_request(OP_ADD, '0, 16'd1);
      send_request(OP_TICK, '0, '0);
      send_request(OP_ADD, '0, 16'd1);
      send_request(OP_ADD, '0, 16'd1);
      send_request(OP_TICK, '0, '0);
   endtask

   // days of a few adds followed by one tick, with clears and noise mixed in
   task automatic test_random_days(input int unsigned item_goal);
      int unsigned sent;
      int unsigned roll;
      sent = 0;
      while (sent < item_goal) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            send_request(OP_CLEAR, WEIGHT_W'($urandom), UNITS_W'($urandom));
            sent++;
         end else if (roll < 10) begin
            case ($urandom_range(2))
               0: send_request(OP_NOP, WEIGHT_W'($urandom), UNITS_W'($urandom));
               1: send_request(OP_ADD, WEIGHT_W'($urandom), '0);
               default: begin
                  // tick out of day order
                  send_request(OP_TICK, WEIGHT_W'($urandom), UNITS_W'($urandom));
                  sent++;
               end
            endcase
         end else begin
            repeat ($urandom_range(3)) begin
               send_request(OP_ADD, pick_weight(), pick_units());
               sent++;
            end
            send_request(OP_TICK, WEIGHT_W'($urandom), UNITS_W'($urandom));
            sent++;
         end
      end
   endtask

   // main sequence
   initial begin
      send_idle_pct      = 8;
      recv_idle_pct      = 71;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= OP_CLEAR;
      req_bus.job_weight <= '0;
      req_bus.job_units  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      wait_for_drain();
      test_table_full();
      test_random_days(380);
      wait_for_drain();

      send_idle_pct = 71;
      recv_idle_pct = 8;
      test_random_days(480);
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_table_full();
      test_random_days(420);

      wait_for_drain();
      repeat (ENTRIES + 8) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
